>>> hw/rtl/assert_macros.svh
// Assertion helpers used by peer_wire_message_parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true on a rising edge of clk outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> hw/rtl/pwmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmp_pkg
// Types and constants of the peer wire message parser.
// ----------------------------------------------------------------------------
package pwmp_pkg;

    localparam int PW_MAX_PIECES = 4096;
    localparam int PW_ADDR_W     = 5;

    localparam logic [7:0]   HS_PROTO_LEN = 8'd19;
    localparam logic [151:0] PROTO_TEXT   = "BitTorrent protocol";

    typedef enum logic [2:0] {
        PH_SHAKE = 3'd0,
        PH_LEN   = 3'd1,
        PH_ID    = 3'd2,
        PH_BODY  = 3'd3,
        PH_HALT  = 3'd4
    } phase_t;

    typedef enum logic [3:0] {
        EV_PEER_ID     = 4'd0,
        EV_HS_OK       = 4'd1,
        EV_KEEPALIVE   = 4'd2,
        EV_FLAGS       = 4'd3,
        EV_HAVE        = 4'd4,
        EV_BITFIELD    = 4'd5,
        EV_PIECE       = 4'd6,
        EV_QUERY       = 4'd7,
        EV_ERR_SHAKE   = 4'd8,
        EV_ERR_HASH    = 4'd9,
        EV_ERR_MSG     = 4'd10,
        EV_ERR_UNSUPP  = 4'd11
    } event_t;

    localparam logic [7:0] MSG_CHOKE      = 8'd0;
    localparam logic [7:0] MSG_UNCHOKE    = 8'd1;
    localparam logic [7:0] MSG_INTEREST   = 8'd2;
    localparam logic [7:0] MSG_NOINTEREST = 8'd3;
    localparam logic [7:0] MSG_HAVE       = 8'd4;
    localparam logic [7:0] MSG_BITFIELD   = 8'd5;
    localparam logic [7:0] MSG_PIECE      = 8'd7;

    localparam logic [1:0] REG_HASH_HI  = 2'd0;
    localparam logic [1:0] REG_HASH_MID = 2'd1;
    localparam logic [1:0] REG_HASH_LO  = 2'd2;
    localparam logic [1:0] REG_PIECES   = 2'd3;

    // Byte j (0..18) of the protocol string.
    function automatic logic [7:0] proto_byte(input logic [4:0] j);
        return 8'(PROTO_TEXT >> (8 * (18 - int'(j))));
    endfunction

endpackage

>>> hw/rtl/pwmp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pwmp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 512,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/peer_wire_message_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peer_wire_message_parser
// Receive-side parser of a peer wire connection with a piece map.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one item per cycle: either a
// received stream byte or a piece map query. The output channel
// (out_valid/out_ready) carries at most one result item per input item.
// The info hash and piece count must be written over the APB port only while
// idle; the block itself does not enforce it. Throughput is one item per
// cycle while in_ready is high. After the edge that accepts an item, its
// result goes to stage one, with the piece map read, then to the output register.
// After reset the piece map is swept to zero, one row of eight pieces a
// cycle, and in_ready stays low until the sweep is done.
// When the receiver stalls, the output register and the stage in front of
// it fill, and then in_ready drops until out_ready returns.
// A malformed or unsupported message produces an error result and halts
// the stream side until reset; queries are still answered.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module peer_wire_message_parser #(
    parameter int MAX_PIECES = pwmp_pkg::PW_MAX_PIECES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pwmp_pkg::PW_ADDR_W-1:0] paddr,
    input  logic [63:0]                    pwdata,
    output logic [63:0]                    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           req_type,
    input  logic [7:0]                     rx_byte,
    input  logic [11:0]                    query_index,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [3:0]                     event_res,
    output logic [7:0]                     data_byte,
    output logic [31:0]                    piece_index,
    output logic [31:0]                    piece_offset,
    output logic                           has_piece,
    output logic                           peer_choking,
    output logic                           peer_interested,
    output logic                           last_byte
);

    import pwmp_pkg::*;

    localparam int ROWS = (MAX_PIECES + 7) / 8;
    localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW   = $clog2(MAX_PIECES + 1);

    // Configuration registers.
    logic [63:0] hash_hi_reg;
    logic [63:0] hash_mid_reg;
    logic [31:0] hash_lo_reg;
    logic [12:0] pieces_reg;
    logic        cfg_we;

    // Parser state.
    phase_t      phase_reg, phase_next;
    logic [31:0] bcnt_reg, bcnt_next;
    logic [31:0] mlen_reg, mlen_next;
    logic [7:0]  mid_reg, mid_next;
    logic [31:0] facc_reg, facc_next;
    logic [31:0] oacc_reg, oacc_next;
    logic        choke_reg, choke_next;
    logic        int_reg, int_next;

    // Clearing sweep.
    logic          clr_active_reg;
    logic [AW-1:0] clr_row_reg;

    // Result of the current item.
    logic        res_valid;
    event_t      res_ev;
    logic [7:0]  res_data;
    logic [31:0] res_index;
    logic [31:0] res_offset;
    logic        res_last;

    // Piece map write from the parser.
    logic [AW-1:0] wr_row;
    logic [7:0]    wr_mask;
    logic [7:0]    wr_bits;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_we;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rdata;
    logic [AW-1:0] mem_raddr;
    logic          mem_re;

    // Stage one.
    logic        s1_valid_reg;
    event_t      s1_ev_reg;
    logic [7:0]  s1_data_reg;
    logic [31:0] s1_index_reg;
    logic [31:0] s1_offset_reg;
    logic        s1_choke_reg;
    logic        s1_int_reg;
    logic        s1_last_reg;
    logic        s1_query_reg;
    logic        s1_inrange_reg;
    logic [2:0]  s1_bank_reg;

    // Output register.
    logic        out_valid_reg;
    event_t      out_ev_reg;
    logic [7:0]  out_data_reg;
    logic [31:0] out_index_reg;
    logic [31:0] out_offset_reg;
    logic        out_has_reg;
    logic        out_choke_reg;
    logic        out_int_reg;
    logic        out_last_reg;

    logic          acc;
    logic          stream_acc;
    logic          out_take;
    logic          s1_adv;
    logic [CW-1:0] cnt;
    logic [31:0]   bf_len;
    logic [159:0]  hash_vec;
    logic [6:0]    hs_pos;
    logic [4:0]    hash_idx;
    logic [7:0]    hash_b;
    logic [7:0]    proto_b;
    logic [31:0]   body_pos;
    logic          body_done;

    // ------------------------------------------------------------------
    // APB configuration port.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_hi_reg  <= '0;
            hash_mid_reg <= '0;
            hash_lo_reg  <= '0;
            pieces_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (paddr[4:3])
                REG_HASH_HI:  hash_hi_reg  <= pwdata;
                REG_HASH_MID: hash_mid_reg <= pwdata;
                REG_HASH_LO:  hash_lo_reg  <= pwdata[31:0];
                REG_PIECES:   pieces_reg   <= pwdata[12:0];
                default:      hash_hi_reg  <= hash_hi_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:3])
            REG_HASH_HI:  prdata = hash_hi_reg;
            REG_HASH_MID: prdata = hash_mid_reg;
            REG_HASH_LO:  prdata = {32'd0, hash_lo_reg};
            REG_PIECES:   prdata = {51'd0, pieces_reg};
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake of the channels.
    // ------------------------------------------------------------------
    assign out_take   = !out_valid_reg || out_ready;
    assign s1_adv     = !s1_valid_reg || out_take;
    assign in_ready   = !clr_active_reg && s1_adv;
    assign acc        = in_valid && in_ready;
    assign stream_acc = acc && !req_type;

    // ------------------------------------------------------------------
    // Parser.
    // ------------------------------------------------------------------
    assign cnt = (32'(pieces_reg) > 32'(MAX_PIECES)) ? CW'(MAX_PIECES) : CW'(pieces_reg);
    assign bf_len   = 32'd1 + ((32'(cnt) + 32'd7) >> 3);
    assign hash_vec = {hash_hi_reg, hash_mid_reg, hash_lo_reg};
    assign hs_pos   = bcnt_reg[6:0];
    assign hash_idx = 5'(hs_pos - 7'd28);
    assign hash_b   = 8'(hash_vec >> (8 * (19 - int'(hash_idx))));
    assign proto_b  = proto_byte(5'(hs_pos - 7'd1));
    assign body_pos  = bcnt_reg;
    assign body_done = (body_pos == mlen_reg - 32'd2);

    always_comb
    begin
        phase_next = phase_reg;
        bcnt_next  = bcnt_reg;
        mlen_next  = mlen_reg;
        mid_next   = mid_reg;
        facc_next  = facc_reg;
        oacc_next  = oacc_reg;
        choke_next = choke_reg;
        int_next   = int_reg;
        res_valid  = 1'b0;
        res_ev     = EV_PEER_ID;
        res_data   = '0;
        res_index  = '0;
        res_offset = '0;
        res_last   = 1'b0;
        wr_row     = '0;
        wr_mask    = '0;
        wr_bits    = '0;

        if (acc && req_type)
        begin
            res_valid = 1'b1;
            res_ev    = EV_QUERY;
        end
        else if (stream_acc)
        begin
            unique case (phase_reg)
                PH_SHAKE:
                begin
                    bcnt_next = bcnt_reg + 32'd1;
                    if (hs_pos == 7'd0)
                    begin
                        if (rx_byte != HS_PROTO_LEN)
                        begin
                            phase_next = PH_HALT;
                            res_valid  = 1'b1;
                            res_ev     = EV_ERR_SHAKE;
                        end
                    end
                    else if (hs_pos < 7'd20)
                    begin
                        if (rx_byte != proto_b)
                        begin
                            phase_next = PH_HALT;
                            res_valid  = 1'b1;
                            res_ev     = EV_ERR_SHAKE;
                        end
                    end
                    else if (hs_pos >= 7'd28 && hs_pos < 7'd48)
                    begin
                        if (rx_byte != hash_b)
                        begin
                            phase_next = PH_HALT;
                            res_valid  = 1'b1;
                            res_ev     = EV_ERR_HASH;
                        end
                    end
                    else if (hs_pos >= 7'd48 && hs_pos < 7'd67)
                    begin
                        res_valid = 1'b1;
                        res_ev    = EV_PEER_ID;
                        res_data  = rx_byte;
                    end
                    else if (hs_pos >= 7'd67)
                    begin
                        // The map is already zero here: nothing writes it
                        // before the handshake completes.
                        phase_next = PH_LEN;
                        bcnt_next  = '0;
                        mlen_next  = '0;
                        res_valid  = 1'b1;
                        res_ev     = EV_HS_OK;
                        res_data   = rx_byte;
                    end
                end

                PH_LEN:
                begin
                    mlen_next = {mlen_reg[23:0], rx_byte};
                    bcnt_next = bcnt_reg + 32'd1;
                    if (bcnt_reg == 32'd3)
                    begin
                        bcnt_next = '0;
                        if (mlen_next == 32'd0)
                        begin
                            res_valid = 1'b1;
                            res_ev    = EV_KEEPALIVE;
                        end
                        else
                        begin
                            phase_next = PH_ID;
                        end
                    end
                end

                PH_ID:
                begin
                    mid_next   = rx_byte;
                    bcnt_next  = '0;
                    facc_next  = '0;
                    oacc_next  = '0;
                    phase_next = PH_BODY;
                    if (rx_byte <= MSG_NOINTEREST)
                    begin
                        if (mlen_reg != 32'd1)
                        begin
                            phase_next = PH_HALT;
                            res_valid  = 1'b1;
                            res_ev     = EV_ERR_MSG;
                        end
                        else
                        begin
                            unique case (rx_byte)
                                MSG_CHOKE:    choke_next = 1'b1;
                                MSG_UNCHOKE:  choke_next = 1'b0;
                                MSG_INTEREST: int_next   = 1'b1;
                                default:      int_next   = 1'b0;
                            endcase
                            phase_next = PH_LEN;
                            mlen_next  = '0;
                            res_valid  = 1'b1;
                            res_ev     = EV_FLAGS;
                        end
                    end
                    else if (rx_byte == MSG_HAVE)
                    begin
                        if (mlen_reg != 32'd5)
                        begin
                            phase_next = PH_HALT;
                            res_valid  = 1'b1;
                            res_ev     = EV_ERR_MSG;
                        end
                    end
                    else if (rx_byte == MSG_BITFIELD)
                    begin
                        if (mlen_reg != bf_len)
                        begin
                            phase_next = PH_HALT;
                            res_valid  = 1'b1;
                            res_ev     = EV_ERR_MSG;
                        end
                        else if (bf_len == 32'd1)
                        begin
                            // No pieces: the id byte closes the message.
                            phase_next = PH_LEN;
                            mlen_next  = '0;
                            res_valid  = 1'b1;
                            res_ev     = EV_BITFIELD;
                        end
                    end
                    else if (rx_byte == MSG_PIECE)
                    begin
                        if (mlen_reg < 32'd9)
                        begin
                            phase_next = PH_HALT;
                            res_valid  = 1'b1;
                            res_ev     = EV_ERR_MSG;
                        end
                    end
                    else
                    begin
                        phase_next = PH_HALT;
                        res_valid  = 1'b1;
                        res_ev     = EV_ERR_UNSUPP;
                    end
                end

                PH_BODY:
                begin
                    bcnt_next = body_pos + 32'd1;
                    if (body_done)
                    begin
                        phase_next = PH_LEN;
                        mlen_next  = '0;
                        bcnt_next  = '0;
                    end
                    if (mid_reg == MSG_HAVE)
                    begin
                        facc_next = {facc_reg[23:0], rx_byte};
                        if (body_done)
                        begin
                            res_valid = 1'b1;
                            if (facc_next >= 32'(cnt))
                            begin
                                phase_next = PH_HALT;
                                res_ev     = EV_ERR_MSG;
                            end
                            else
                            begin
                                wr_row    = facc_next[AW+2:3];
                                wr_mask   = 8'(1) << facc_next[2:0];
                                wr_bits   = 8'hFF;
                                res_ev    = EV_HAVE;
                                res_index = facc_next;
                            end
                        end
                    end
                    else if (mid_reg == MSG_BITFIELD)
                    begin
                        // Bank k holds piece 8*row + k; the first byte bit is bank 0.
                        wr_row = body_pos[AW-1:0];
                        for (int k = 0; k < 8; k++)
                        begin
                            wr_mask[k] = ({3'd0, body_pos, 3'(k)} < 38'(cnt));
                            wr_bits[k] = rx_byte[7-k];
                        end
                        if (body_done)
                        begin
                            res_valid = 1'b1;
                            res_ev    = EV_BITFIELD;
                        end
                    end
                    else if (body_pos < 32'd4)
                    begin
                        facc_next = {facc_reg[23:0], rx_byte};
                    end
                    else if (body_pos < 32'd8)
                    begin
                        oacc_next = {oacc_reg[23:0], rx_byte};
                    end
                    else
                    begin
                        res_valid  = 1'b1;
                        res_ev     = EV_PIECE;
                        res_data   = rx_byte;
                        res_index  = facc_reg;
                        res_offset = oacc_reg + (body_pos - 32'd8);
                        res_last   = body_done;
                    end
                end

                default:
                begin
                    phase_next = PH_HALT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SHAKE;
            bcnt_reg  <= '0;
            mlen_reg  <= '0;
            mid_reg   <= '0;
            facc_reg  <= '0;
            oacc_reg  <= '0;
            choke_reg <= 1'b1;
            int_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            bcnt_reg  <= bcnt_next;
            mlen_reg  <= mlen_next;
            mid_reg   <= mid_next;
            facc_reg  <= facc_next;
            oacc_reg  <= oacc_next;
            choke_reg <= choke_next;
            int_reg   <= int_next;
        end
    end

    // ------------------------------------------------------------------
    // Piece map: eight one-bit banks, one row per eight pieces.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_row_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_row_reg <= clr_row_reg + AW'(1);
            if (clr_row_reg == AW'(ROWS - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    assign mem_we    = clr_active_reg ? 8'hFF : wr_mask;
    assign mem_waddr = clr_active_reg ? clr_row_reg : wr_row;
    assign mem_wdata = clr_active_reg ? 8'h00 : wr_bits;
    assign mem_re    = acc && req_type;
    assign mem_raddr = AW'(query_index >> 3);

    for (genvar g = 0; g < 8; g++)
    begin : g_bank
        pwmp_ram #(
            .WIDTH (1),
            .DEPTH (ROWS)
        ) u_bank (
            .clk   (clk),
            .we    (mem_we[g]),
            .waddr (mem_waddr),
            .wdata (mem_wdata[g]),
            .re    (mem_re),
            .raddr (mem_raddr),
            .rdata (mem_rdata[g])
        );
    end

    // ------------------------------------------------------------------
    // Stage one and output register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= acc && res_valid;
            end
            if (out_take)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && acc)
        begin
            s1_ev_reg      <= res_ev;
            s1_data_reg    <= res_data;
            s1_index_reg   <= res_index;
            s1_offset_reg  <= res_offset;
            s1_choke_reg   <= choke_next;
            s1_int_reg     <= int_next;
            s1_last_reg    <= res_last;
            s1_query_reg   <= req_type;
            s1_inrange_reg <= (32'(query_index) < 32'(MAX_PIECES));
            s1_bank_reg    <= query_index[2:0];
        end
        if (out_take && s1_valid_reg)
        begin
            out_ev_reg     <= s1_ev_reg;
            out_data_reg   <= s1_data_reg;
            out_index_reg  <= s1_index_reg;
            out_offset_reg <= s1_offset_reg;
            out_has_reg    <= s1_query_reg && s1_inrange_reg && mem_rdata[s1_bank_reg];
            out_choke_reg  <= s1_choke_reg;
            out_int_reg    <= s1_int_reg;
            out_last_reg   <= s1_last_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign event_res       = out_ev_reg;
    assign data_byte       = out_data_reg;
    assign piece_index     = out_index_reg;
    assign piece_offset    = out_offset_reg;
    assign has_piece       = out_has_reg;
    assign peer_choking    = out_choke_reg;
    assign peer_interested = out_int_reg;
    assign last_byte       = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `ASSERT_CLK(a_halt_sticky, phase_reg == PH_HALT |=> phase_reg == PH_HALT,
        "parser left the halted phase")
    `ASSERT_CLK(a_halt_silent, (stream_acc && phase_reg == PH_HALT) |=> !s1_valid_reg,
        "stream item produced a result while halted")
    `ASSERT_NEVER(a_last_piece, out_valid_reg && out_last_reg && out_ev_reg != EV_PIECE,
        "last byte flag on a result that is not a piece byte")
    `ASSERT_NEVER(a_clear_block, clr_active_reg && in_valid && in_ready,
        "item accepted during the piece map sweep")

endmodule
